/* hdl/ffa_pkg.sv */
// Shared types and constants for the first-fit block allocator.
// Used by ffa_dpath, ffa_ctrl and first_fit_block_allocator; no dependencies.
package ffa_pkg;

	localparam int MAX_BLOCKS = 64;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int ADDR_W     = 16;

	localparam logic [ADDR_W-1:0] RST_BASE = ADDR_W'(20);
	localparam logic [ADDR_W-1:0] RST_END  = ADDR_W'(200);

	localparam logic REG_BASE = 1'b0;
	localparam logic REG_END  = 1'b1;

	typedef enum logic [1:0] {
		K_ALLOC = 2'd0,
		K_FREE  = 2'd1,
		K_READ  = 2'd2,
		K_INIT  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_NOFIT = 3'd1,
		ST_BAD   = 3'd2,
		ST_FREE  = 3'd3,
		ST_FULL  = 3'd4
	} stat_t;

	typedef struct packed {
		logic              alloc;
		logic [ADDR_W-1:0] size;
		logic [ADDR_W-1:0] addr;
	} ent_t;

	typedef enum logic [4:0] {
		C_NOP,
		C_RST_WR,
		C_LOAD,
		C_PTR_ONE,
		C_PTR_INC,
		C_A_RD,
		C_A_EXACT,
		C_A_SPLIT,
		C_U_RD,
		C_U_WR,
		C_SPL_HI,
		C_SPL_LO,
		C_RD_NUM,
		C_CUR_NUM,
		C_RD_NX,
		C_F_NX,
		C_RD_PV,
		C_F_PV,
		C_F_WC,
		C_D_RD,
		C_D_WR,
		C_D_DONE,
		C_I_EMPTY,
		C_I_WR,
		C_FIN
	} cmd_t;

	typedef enum logic [4:0] {
		S_BOOT,
		S_IDLE,
		S_DISP,
		S_A_RD,
		S_A_EV,
		S_U_RD,
		S_U_WR,
		S_A_LO,
		S_F_EV,
		S_F_RN,
		S_F_NX,
		S_F_RP,
		S_F_PV,
		S_F_WC,
		S_D_RD,
		S_D_WR,
		S_R_EV,
		S_FIN
	} state_t;

	// controller -> datapath
	typedef struct packed {
		cmd_t  cmd;
		logic  set_res;
		stat_t code;
		logic  hit;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		kind_t kind;
		logic  req_zero;
		logic  num_bad;
		logic  num_lt_cnt;
		logic  num_ge2;
		logic  ptr_gt_cnt;
		logic  rd_fit;
		logic  rd_exact;
		logic  rd_alloc;
		logic  cnt_full;
		logic  u_more;
		logic  d_more;
		logic  range_bad;
		logic  out_free;
	} sts_t;

endpackage

/* hdl/ffa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* hdl/ffa_dpath.sv */
// Datapath of the allocator: block table RAM, count, pointers, working entry,
// config registers and the result register. Depends on ffa_pkg and ffa_ram.
module ffa_dpath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ffa_pkg::ctl_t              ctl,
	output ffa_pkg::sts_t              sts,
	input  logic [1:0]                 in_kind,
	input  logic [ffa_pkg::ADDR_W-1:0] in_req,
	input  logic [ffa_pkg::IDX_W-1:0]  in_num,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_index,
	input  logic [ffa_pkg::ADDR_W-1:0] cfg_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [2:0]                 out_status,
	output logic [ffa_pkg::IDX_W-1:0]  out_index,
	output logic [ffa_pkg::ADDR_W-1:0] out_address,
	output logic [ffa_pkg::ADDR_W-1:0] out_size,
	output logic                       out_allocated,
	output logic [ffa_pkg::IDX_W-1:0]  out_total
);

	localparam int IW = ffa_pkg::IDX_W;
	localparam int AW = ffa_pkg::ADDR_W;

	logic [AW-1:0]   base_q, end_q;
	ffa_pkg::kind_t  kind_q;
	logic [AW-1:0]   req_q;
	logic [IW-1:0]   num_q;
	logic [IW-1:0]   cnt_q;
	logic [IW:0]     ptr_q;
	logic [IW-1:0]   at_q;
	logic [1:0]      mrg_q;
	logic [AW-1:0]   cur_addr_q, cur_size_q;
	logic            cur_alloc_q;
	ffa_pkg::stat_t  code_q;
	logic            hit_q;

	logic            wr_en, rd_en;
	logic [IW-1:0]   wr_addr, rd_addr;
	ffa_pkg::ent_t   wr_ent, rd_ent;
	logic [IW:0]     ptr_mrg;

	assign cfg_ready = 1'b1;
	assign ptr_mrg   = ptr_q + (IW+1)'(mrg_q);

	ffa_ram #(
		.WIDTH ($bits(ffa_pkg::ent_t)),
		.DEPTH (ffa_pkg::MAX_BLOCKS)
	) u_tbl (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_ent),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_ent)
	);

	// table read and write port selection
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = at_q;
		wr_ent  = '{alloc: 1'b0, size: cur_size_q, addr: cur_addr_q};
		rd_en   = 1'b1;
		rd_addr = ptr_q[IW-1:0];
		case (ctl.cmd)
			ffa_pkg::C_RST_WR: begin
				wr_en   = 1'b1;
				wr_addr = IW'(1);
				wr_ent  = '{alloc: 1'b0, size: ffa_pkg::RST_END - ffa_pkg::RST_BASE,
					addr: ffa_pkg::RST_BASE};
			end
			ffa_pkg::C_I_WR: begin
				wr_en   = 1'b1;
				wr_addr = IW'(1);
				wr_ent  = '{alloc: 1'b0, size: end_q - base_q, addr: base_q};
			end
			ffa_pkg::C_A_EXACT: begin
				wr_en   = 1'b1;
				wr_addr = ptr_q[IW-1:0];
				wr_ent  = '{alloc: 1'b1, size: rd_ent.size, addr: rd_ent.addr};
			end
			ffa_pkg::C_U_RD: rd_addr = ptr_q[IW-1:0] - IW'(1);
			ffa_pkg::C_U_WR, ffa_pkg::C_D_WR: begin
				wr_en   = 1'b1;
				wr_addr = ptr_q[IW-1:0];
				wr_ent  = rd_ent;
			end
			ffa_pkg::C_SPL_HI: begin
				wr_en   = 1'b1;
				wr_addr = at_q + IW'(1);
				wr_ent  = '{alloc: 1'b0, size: cur_size_q - req_q, addr: cur_addr_q + req_q};
			end
			ffa_pkg::C_SPL_LO: begin
				wr_en   = 1'b1;
				wr_ent  = '{alloc: 1'b1, size: req_q, addr: cur_addr_q};
			end
			ffa_pkg::C_RD_NUM: rd_addr = num_q;
			ffa_pkg::C_RD_NX:  rd_addr = num_q + IW'(1);
			ffa_pkg::C_RD_PV:  rd_addr = num_q - IW'(1);
			ffa_pkg::C_F_WC:   wr_en   = 1'b1;
			ffa_pkg::C_D_RD:   rd_addr = ptr_mrg[IW-1:0];
			default: ;
		endcase
	end

	// status back to the controller
	always_comb begin
		sts.kind       = kind_q;
		sts.req_zero   = (req_q == '0);
		sts.num_bad    = (num_q == '0) || (num_q > cnt_q);
		sts.num_lt_cnt = (num_q < cnt_q);
		sts.num_ge2    = (num_q >= IW'(2));
		sts.ptr_gt_cnt = (ptr_q > {1'b0, cnt_q});
		sts.rd_fit     = !rd_ent.alloc && (rd_ent.size >= req_q);
		sts.rd_exact   = (rd_ent.size == req_q);
		sts.rd_alloc   = rd_ent.alloc;
		sts.cnt_full   = (cnt_q >= IW'(ffa_pkg::MAX_BLOCKS - 1));
		sts.u_more     = (ptr_q > ({1'b0, at_q} + (IW+1)'(1)));
		sts.d_more     = (mrg_q != 2'd0) && (ptr_mrg <= {1'b0, cnt_q});
		sts.range_bad  = (end_q <= base_q);
		sts.out_free   = !out_valid || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= ffa_pkg::RST_BASE;
			end_q     <= ffa_pkg::RST_END;
			cnt_q     <= IW'(1);
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					ffa_pkg::REG_BASE: base_q <= cfg_data;
					ffa_pkg::REG_END:  end_q  <= cfg_data;
					default: ;
				endcase
			end
			case (ctl.cmd)
				ffa_pkg::C_A_SPLIT: cnt_q <= cnt_q + IW'(1);
				ffa_pkg::C_D_DONE:  cnt_q <= cnt_q - IW'(mrg_q);
				ffa_pkg::C_I_EMPTY: cnt_q <= '0;
				ffa_pkg::C_I_WR:    cnt_q <= IW'(1);
				default: ;
			endcase
			if (ctl.cmd == ffa_pkg::C_FIN) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// working registers and result payload
	always_ff @(posedge clk) begin
		if (ctl.set_res) begin
			code_q <= ctl.code;
			hit_q  <= ctl.hit;
		end
		case (ctl.cmd)
			ffa_pkg::C_LOAD: begin
				kind_q <= ffa_pkg::kind_t'(in_kind);
				req_q  <= in_req;
				num_q  <= in_num;
			end
			ffa_pkg::C_PTR_ONE: ptr_q <= (IW+1)'(1);
			ffa_pkg::C_PTR_INC, ffa_pkg::C_D_WR: ptr_q <= ptr_q + (IW+1)'(1);
			ffa_pkg::C_U_WR: ptr_q <= ptr_q - (IW+1)'(1);
			ffa_pkg::C_A_EXACT: begin
				at_q        <= ptr_q[IW-1:0];
				cur_addr_q  <= rd_ent.addr;
				cur_size_q  <= rd_ent.size;
				cur_alloc_q <= 1'b1;
			end
			ffa_pkg::C_A_SPLIT: begin
				at_q       <= ptr_q[IW-1:0];
				cur_addr_q <= rd_ent.addr;
				cur_size_q <= rd_ent.size;
				ptr_q      <= {1'b0, cnt_q} + (IW+1)'(1);
			end
			ffa_pkg::C_SPL_LO: begin
				cur_size_q  <= req_q;
				cur_alloc_q <= 1'b1;
			end
			ffa_pkg::C_CUR_NUM: begin
				at_q        <= num_q;
				cur_addr_q  <= rd_ent.addr;
				cur_size_q  <= rd_ent.size;
				cur_alloc_q <= rd_ent.alloc;
				mrg_q       <= 2'd0;
			end
			ffa_pkg::C_F_NX: begin
				if (!rd_ent.alloc) begin
					cur_size_q <= cur_size_q + rd_ent.size;
					mrg_q      <= 2'd1;
				end
			end
			ffa_pkg::C_F_PV: begin
				if (!rd_ent.alloc) begin
					cur_addr_q <= rd_ent.addr;
					cur_size_q <= cur_size_q + rd_ent.size;
					at_q       <= num_q - IW'(1);
					mrg_q      <= mrg_q + 2'd1;
				end
			end
			ffa_pkg::C_F_WC: begin
				cur_alloc_q <= 1'b0;
				ptr_q       <= {1'b0, at_q} + (IW+1)'(1);
			end
			ffa_pkg::C_I_WR: begin
				at_q        <= IW'(1);
				cur_addr_q  <= base_q;
				cur_size_q  <= end_q - base_q;
				cur_alloc_q <= 1'b0;
			end
			ffa_pkg::C_FIN: begin
				out_status    <= code_q;
				out_total     <= cnt_q;
				out_index     <= hit_q ? at_q : '0;
				out_address   <= hit_q ? cur_addr_q : '0;
				out_size      <= hit_q ? cur_size_q : '0;
				out_allocated <= hit_q && cur_alloc_q;
			end
			default: ;
		endcase
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= IW'(ffa_pkg::MAX_BLOCKS - 1))
		else $error("block count past table capacity");

	a_no_wr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> wr_addr != '0)
		else $error("write to unused table slot 0");

	a_split_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.cmd == ffa_pkg::C_A_SPLIT |-> !sts.cnt_full)
		else $error("split issued on full table");

endmodule

/* hdl/ffa_ctrl.sv */
// Controller state machine for the allocator: sequences scans, shifts and
// merges through datapath commands. Depends on ffa_pkg.
module ffa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ffa_pkg::sts_t sts,
	output ffa_pkg::ctl_t ctl
);

	ffa_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffa_pkg::S_BOOT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		ctl.cmd     = ffa_pkg::C_NOP;
		ctl.set_res = 1'b0;
		ctl.code    = ffa_pkg::ST_OK;
		ctl.hit     = 1'b0;
		case (state_q)
			ffa_pkg::S_BOOT: begin
				ctl.cmd = ffa_pkg::C_RST_WR;
				state_d = ffa_pkg::S_IDLE;
			end
			ffa_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.cmd = ffa_pkg::C_LOAD;
					state_d = ffa_pkg::S_DISP;
				end
			end
			ffa_pkg::S_DISP: begin
				case (sts.kind)
					ffa_pkg::K_ALLOC: begin
						if (sts.req_zero) begin
							ctl.set_res = 1'b1;
							ctl.code    = ffa_pkg::ST_BAD;
							state_d     = ffa_pkg::S_FIN;
						end else begin
							ctl.cmd = ffa_pkg::C_PTR_ONE;
							state_d = ffa_pkg::S_A_RD;
						end
					end
					ffa_pkg::K_FREE, ffa_pkg::K_READ: begin
						if (sts.num_bad) begin
							ctl.set_res = 1'b1;
							ctl.code    = ffa_pkg::ST_BAD;
							state_d     = ffa_pkg::S_FIN;
						end else begin
							ctl.cmd = ffa_pkg::C_RD_NUM;
							state_d = (sts.kind == ffa_pkg::K_FREE) ?
								ffa_pkg::S_F_EV : ffa_pkg::S_R_EV;
						end
					end
					default: begin
						ctl.set_res = 1'b1;
						state_d     = ffa_pkg::S_FIN;
						if (sts.range_bad) begin
							ctl.cmd  = ffa_pkg::C_I_EMPTY;
							ctl.code = ffa_pkg::ST_BAD;
						end else begin
							ctl.cmd = ffa_pkg::C_I_WR;
							ctl.hit = 1'b1;
						end
					end
				endcase
			end
			// first-fit scan: read an entry, then evaluate it
			ffa_pkg::S_A_RD: begin
				if (sts.ptr_gt_cnt) begin
					ctl.set_res = 1'b1;
					ctl.code    = ffa_pkg::ST_NOFIT;
					state_d     = ffa_pkg::S_FIN;
				end else begin
					ctl.cmd = ffa_pkg::C_A_RD;
					state_d = ffa_pkg::S_A_EV;
				end
			end
			ffa_pkg::S_A_EV: begin
				if (!sts.rd_fit) begin
					ctl.cmd = ffa_pkg::C_PTR_INC;
					state_d = ffa_pkg::S_A_RD;
				end else if (sts.rd_exact) begin
					ctl.cmd     = ffa_pkg::C_A_EXACT;
					ctl.set_res = 1'b1;
					ctl.hit     = 1'b1;
					state_d     = ffa_pkg::S_FIN;
				end else if (sts.cnt_full) begin
					ctl.set_res = 1'b1;
					ctl.code    = ffa_pkg::ST_FULL;
					state_d     = ffa_pkg::S_FIN;
				end else begin
					ctl.cmd = ffa_pkg::C_A_SPLIT;
					state_d = ffa_pkg::S_U_RD;
				end
			end
			// open a slot above the split block, top entry first
			ffa_pkg::S_U_RD: begin
				if (sts.u_more) begin
					ctl.cmd = ffa_pkg::C_U_RD;
					state_d = ffa_pkg::S_U_WR;
				end else begin
					ctl.cmd = ffa_pkg::C_SPL_HI;
					state_d = ffa_pkg::S_A_LO;
				end
			end
			ffa_pkg::S_U_WR: begin
				ctl.cmd = ffa_pkg::C_U_WR;
				state_d = ffa_pkg::S_U_RD;
			end
			ffa_pkg::S_A_LO: begin
				ctl.cmd     = ffa_pkg::C_SPL_LO;
				ctl.set_res = 1'b1;
				ctl.hit     = 1'b1;
				state_d     = ffa_pkg::S_FIN;
			end
			ffa_pkg::S_F_EV: begin
				ctl.cmd = ffa_pkg::C_CUR_NUM;
				if (!sts.rd_alloc) begin
					ctl.set_res = 1'b1;
					ctl.code    = ffa_pkg::ST_FREE;
					ctl.hit     = 1'b1;
					state_d     = ffa_pkg::S_FIN;
				end else begin
					state_d = ffa_pkg::S_F_RN;
				end
			end
			ffa_pkg::S_F_RN: begin
				if (sts.num_lt_cnt) begin
					ctl.cmd = ffa_pkg::C_RD_NX;
					state_d = ffa_pkg::S_F_NX;
				end else begin
					state_d = ffa_pkg::S_F_RP;
				end
			end
			ffa_pkg::S_F_NX: begin
				ctl.cmd = ffa_pkg::C_F_NX;
				state_d = ffa_pkg::S_F_RP;
			end
			ffa_pkg::S_F_RP: begin
				if (sts.num_ge2) begin
					ctl.cmd = ffa_pkg::C_RD_PV;
					state_d = ffa_pkg::S_F_PV;
				end else begin
					state_d = ffa_pkg::S_F_WC;
				end
			end
			ffa_pkg::S_F_PV: begin
				ctl.cmd = ffa_pkg::C_F_PV;
				state_d = ffa_pkg::S_F_WC;
			end
			ffa_pkg::S_F_WC: begin
				ctl.cmd = ffa_pkg::C_F_WC;
				state_d = ffa_pkg::S_D_RD;
			end
			// close the gap left by merged entries
			ffa_pkg::S_D_RD: begin
				if (sts.d_more) begin
					ctl.cmd = ffa_pkg::C_D_RD;
					state_d = ffa_pkg::S_D_WR;
				end else begin
					ctl.cmd     = ffa_pkg::C_D_DONE;
					ctl.set_res = 1'b1;
					ctl.hit     = 1'b1;
					state_d     = ffa_pkg::S_FIN;
				end
			end
			ffa_pkg::S_D_WR: begin
				ctl.cmd = ffa_pkg::C_D_WR;
				state_d = ffa_pkg::S_D_RD;
			end
			ffa_pkg::S_R_EV: begin
				ctl.cmd     = ffa_pkg::C_CUR_NUM;
				ctl.set_res = 1'b1;
				ctl.hit     = 1'b1;
				state_d     = ffa_pkg::S_FIN;
			end
			ffa_pkg::S_FIN: begin
				if (sts.out_free) begin
					ctl.cmd = ffa_pkg::C_FIN;
					state_d = ffa_pkg::S_IDLE;
				end
			end
			default: state_d = ffa_pkg::S_IDLE;
		endcase
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ffa_pkg::S_DISP)
		else $error("accepted beat not dispatched");

	a_fin_release: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ffa_pkg::S_FIN && sts.out_free |=> state_q == ffa_pkg::S_IDLE)
		else $error("result load did not return to idle");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> ctl.set_res == 1'b0)
		else $error("result latched while idle");

endmodule

/* hdl/first_fit_block_allocator.sv */
// First-fit block allocator: an ordered table of up to 63 blocks kept in a
// 64-entry RAM, one read and one write per cycle, walked by a controller that
// takes one item at a time. Allocate scans the entries in order and shifts
// entries up on a split; free merges with free neighbours and shifts entries
// down after a merge. After reset the initial free block is written before
// the first beat is taken. A finished result waits in the output register
// while the next beat is accepted.
// Depends on ffa_pkg, ffa_ram, ffa_dpath, ffa_ctrl.
module first_fit_block_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // request_size[15:0], block_number[21:16], zero pad
	input  logic [1:0]  s_axis_tuser,  // kind[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // status[2:0], result_index[8:3],
	                                   // result_address[24:9], result_size[40:25],
	                                   // result_allocated[41], block_total[47:42]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	ffa_pkg::ctl_t ctl;
	ffa_pkg::sts_t sts;

	logic [2:0]                 r_status;
	logic [ffa_pkg::IDX_W-1:0]  r_index, r_total;
	logic [ffa_pkg::ADDR_W-1:0] r_address, r_size;
	logic                       r_alloc;

	ffa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	ffa_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.in_kind       (s_axis_tuser),
		.in_req        (s_axis_tdata[15:0]),
		.in_num        (s_axis_tdata[21:16]),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_status    (r_status),
		.out_index     (r_index),
		.out_address   (r_address),
		.out_size      (r_size),
		.out_allocated (r_alloc),
		.out_total     (r_total)
	);

	assign m_axis_tdata = {r_total, r_alloc, r_size, r_address, r_index, r_status};

endmodule

/* verif/first_fit_block_allocator_tb.sv */
// Self-checking testbench for first_fit_block_allocator: directed table plus
// random allocate/free/read/init traffic, checked against an in-bench model.
// Depends on ffa_pkg and the allocator RTL.
`timescale 1ns / 100ps

module first_fit_block_allocator_tb;

	localparam int N_RANDOM  = 1700;
	localparam int CYC_LIMIT = 1500000;

	typedef struct {
		logic [2:0]  status;
		logic [5:0]  index;
		logic [15:0] addr;
		logic [15:0] size;
		logic        alloc;
		logic [5:0]  total;
	} res_t;

	typedef struct {
		ffa_pkg::kind_t kind;
		logic [15:0]    req;
		logic [5:0]     num;
		logic           fixed;
		res_t           want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;

	first_fit_block_allocator i_dut (.*);

	always #10 clk = ~clk;

	// model state
	logic [15:0] tbl_addr [ffa_pkg::MAX_BLOCKS];
	logic [15:0] tbl_size [ffa_pkg::MAX_BLOCKS];
	logic        tbl_alloc [ffa_pkg::MAX_BLOCKS];
	int          blk_cnt;
	logic [15:0] base_reg, end_reg;

	res_t pending_results [$];
	int   n_errors, n_results, n_cycles, n_items;
	bit   calm;
	int   kind_seen [4];

	function automatic res_t make_result(logic [2:0] st, int idx);
		res_t r;
		r.status = st;
		r.total = 6'(blk_cnt);
		r.index = '0; r.addr = '0; r.size = '0; r.alloc = 1'b0;
		if (idx != 0) begin
			r.index = 6'(idx);
			r.addr = tbl_addr[idx];
			r.size = tbl_size[idx];
			r.alloc = tbl_alloc[idx];
		end
		return r;
	endfunction

	function automatic bit rebuild_table();
		for (int i = 0; i < ffa_pkg::MAX_BLOCKS; i++) begin
			tbl_addr[i] = '0; tbl_size[i] = '0; tbl_alloc[i] = 1'b0;
		end
		if (end_reg <= base_reg) begin
			blk_cnt = 0;
			return 1'b0;
		end
		tbl_addr[1] = base_reg;
		tbl_size[1] = end_reg - base_reg;
		blk_cnt = 1;
		return 1'b1;
	endfunction

	function automatic void drop_entry(int p);
		for (int i = p; i < blk_cnt; i++) begin
			tbl_addr[i] = tbl_addr[i+1];
			tbl_size[i] = tbl_size[i+1];
			tbl_alloc[i] = tbl_alloc[i+1];
		end
		blk_cnt--;
	endfunction

	function automatic res_t allocate_block(logic [15:0] req);
		if (req == 0) return make_result(ffa_pkg::ST_BAD, 0);
		for (int i = 1; i <= blk_cnt; i++) begin
			if (tbl_alloc[i] || tbl_size[i] < req) continue;
			if (tbl_size[i] == req) begin
				tbl_alloc[i] = 1'b1;
				return make_result(ffa_pkg::ST_OK, i);
			end
			if (blk_cnt >= ffa_pkg::MAX_BLOCKS - 1) return make_result(ffa_pkg::ST_FULL, 0);
			blk_cnt++;
			for (int j = blk_cnt; j > i + 1; j--) begin
				tbl_addr[j] = tbl_addr[j-1];
				tbl_size[j] = tbl_size[j-1];
				tbl_alloc[j] = tbl_alloc[j-1];
			end
			tbl_alloc[i+1] = 1'b0;
			tbl_addr[i+1] = tbl_addr[i] + req;
			tbl_size[i+1] = tbl_size[i] - req;
			tbl_alloc[i] = 1'b1;
			tbl_size[i] = req;
			return make_result(ffa_pkg::ST_OK, i);
		end
		return make_result(ffa_pkg::ST_NOFIT, 0);
	endfunction

	function automatic res_t release_block(int k);
		int at;
		at = k;
		if (k == 0 || k > blk_cnt) return make_result(ffa_pkg::ST_BAD, 0);
		if (!tbl_alloc[k]) return make_result(ffa_pkg::ST_FREE, k);
		tbl_alloc[k] = 1'b0;
		if (k + 1 <= blk_cnt && !tbl_alloc[k+1]) begin
			tbl_size[k] = tbl_size[k] + tbl_size[k+1];
			drop_entry(k + 1);
		end
		if (k >= 2 && !tbl_alloc[k-1]) begin
			tbl_size[k-1] = tbl_size[k-1] + tbl_size[k];
			drop_entry(k);
			at = k - 1;
		end
		return make_result(ffa_pkg::ST_OK, at);
	endfunction

	function automatic res_t predict_result(ffa_pkg::kind_t kind, logic [15:0] req,
		logic [5:0] num);
		case (kind)
			ffa_pkg::K_ALLOC: return allocate_block(req);
			ffa_pkg::K_FREE:  return release_block(num);
			ffa_pkg::K_READ: begin
				if (num == 0 || num > blk_cnt) return make_result(ffa_pkg::ST_BAD, 0);
				return make_result(ffa_pkg::ST_OK, num);
			end
			default: begin
				if (rebuild_table()) return make_result(ffa_pkg::ST_OK, 1);
				return make_result(ffa_pkg::ST_BAD, 0);
			end
		endcase
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch on result %0d: %s got %0d expected %0d", n_results, what, got, want);
		n_errors++;
	endtask

	// valid drops here and in wait_drained, so a beat that follows at once keeps valid high
	task automatic idle_burst();
		if (!calm && $urandom_range(3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(16, 1)) @(posedge clk);
		end
	endtask

	task automatic send_item(ffa_pkg::kind_t kind, logic [15:0] req, logic [5:0] num);
		idle_burst();
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {2'b00, num, req};
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(predict_result(kind, req, num));
		kind_seen[kind]++;
		n_items++;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (idx == ffa_pkg::REG_BASE) base_reg = val;
		else end_reg = val;
	endtask

	// result side: random stalls, compare against oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_results.size() == 0) begin
					$display("unexpected result beat %h", m_axis_tdata);
					n_errors++;
				end else begin
					res_t w;
					w = pending_results.pop_front();
					if (m_axis_tdata[2:0] != w.status) report("status", m_axis_tdata[2:0], w.status);
					if (m_axis_tdata[8:3] != w.index) report("index", m_axis_tdata[8:3], w.index);
					if (m_axis_tdata[24:9] != w.addr) report("address", m_axis_tdata[24:9], w.addr);
					if (m_axis_tdata[40:25] != w.size) report("size", m_axis_tdata[40:25], w.size);
					if (m_axis_tdata[41] != w.alloc) report("allocated", m_axis_tdata[41], w.alloc);
					if (m_axis_tdata[47:42] != w.total) report("total", m_axis_tdata[47:42], w.total);
				end
				n_results++;
			end
		end
	end

	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (calm) m_axis_tready <= 1'b1;
			else if (stall > 0) begin
				stall--;
				m_axis_tready <= 1'b0;
			end else if ($urandom_range(5) == 0) begin
				stall = $urandom_range(16, 1) - 1;
				m_axis_tready <= 1'b0;
			end else m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYC_LIMIT) begin
			$display("timeout after %0d cycles", n_cycles);
			$display("status: fail");
			$finish;
		end
	end

	function automatic row_t row(ffa_pkg::kind_t k, logic [15:0] rq, logic [5:0] nm, logic fx,
		logic [2:0] st, logic [5:0] ix, logic [15:0] ad, logic [15:0] sz, logic al,
		logic [5:0] tt);
		row_t r;
		r.kind = k; r.req = rq; r.num = nm; r.fixed = fx;
		r.want.status = st; r.want.index = ix; r.want.addr = ad;
		r.want.size = sz; r.want.alloc = al; r.want.total = tt;
		return r;
	endfunction

	initial begin
		row_t           rows [$];
		int             live;
		ffa_pkg::kind_t k;

		n_errors = 0; n_results = 0; n_cycles = 0; n_items = 0; calm = 0;
		base_reg = ffa_pkg::RST_BASE;
		end_reg = ffa_pkg::RST_END;
		void'(rebuild_table());
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; fixed rows state the expected beat outright
		rows.push_back(row(ffa_pkg::K_READ, 16'h0, 6'd1, 1, ffa_pkg::ST_OK, 1, 20, 180, 0, 1));
		rows.push_back(row(ffa_pkg::K_READ, 16'h0, 6'd0, 1, ffa_pkg::ST_BAD, 0, 0, 0, 0, 1));
		rows.push_back(row(ffa_pkg::K_READ, 16'h0, 6'd2, 1, ffa_pkg::ST_BAD, 0, 0, 0, 0, 1));
		rows.push_back(row(ffa_pkg::K_ALLOC, 16'h0, 6'd0, 1, ffa_pkg::ST_BAD, 0, 0, 0, 0, 1));
		rows.push_back(row(ffa_pkg::K_ALLOC, 16'hFFFF, 6'd63, 1, ffa_pkg::ST_NOFIT,
			0, 0, 0, 0, 1));
		rows.push_back(row(ffa_pkg::K_FREE, 16'h0, 6'd1, 1, ffa_pkg::ST_FREE, 1, 20, 180, 0, 1));
		rows.push_back(row(ffa_pkg::K_ALLOC, 16'd10, 6'd0, 1, ffa_pkg::ST_OK, 1, 20, 10, 1, 2));
		rows.push_back(row(ffa_pkg::K_ALLOC, 16'd20, 6'd0, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(row(ffa_pkg::K_ALLOC, 16'd30, 6'd0, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(row(ffa_pkg::K_FREE, 16'h0, 6'd2, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(row(ffa_pkg::K_FREE, 16'h0, 6'd1, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(row(ffa_pkg::K_FREE, 16'h0, 6'd63, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(row(ffa_pkg::K_READ, 16'h0, 6'd2, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(row(ffa_pkg::K_ALLOC, 16'd120, 6'd0, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(row(ffa_pkg::K_FREE, 16'h0, 6'd2, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(row(ffa_pkg::K_INIT, 16'hFFFF, 6'd63, 1, ffa_pkg::ST_OK,
			1, 20, 180, 0, 1));
		rows.push_back(row(ffa_pkg::K_ALLOC, 16'd180, 6'd0, 1, ffa_pkg::ST_OK,
			1, 20, 180, 1, 1));
		rows.push_back(row(ffa_pkg::K_FREE, 16'h0, 6'd1, 1, ffa_pkg::ST_OK, 1, 20, 180, 0, 1));
		foreach (rows[i]) begin
			send_item(rows[i].kind, rows[i].req, rows[i].num);
			if (rows[i].fixed) begin
				void'(pending_results.pop_back());
				pending_results.push_back(rows[i].want);
			end
		end
		wait_drained();

		// fill the table to its limit to reach the table-full case
		for (int i = 0; i < 66; i++)
			send_item(ffa_pkg::K_ALLOC, 16'd1, 6'($urandom_range(63)));
		send_item(ffa_pkg::K_FREE, 16'h0, 6'd1);
		send_item(ffa_pkg::K_READ, 16'h0, 6'(blk_cnt));
		wait_drained();

		// settings: extremes, empty range, wide range, random
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					write_reg(ffa_pkg::REG_BASE, 16'd0);
					write_reg(ffa_pkg::REG_END, 16'hFFFF);
				end
				1: begin
					write_reg(ffa_pkg::REG_BASE, 16'hFFFE);
					write_reg(ffa_pkg::REG_END, 16'hFFFF);
				end
				2: begin
					write_reg(ffa_pkg::REG_BASE, 16'd500);
					write_reg(ffa_pkg::REG_END, 16'd500);
				end
				3: begin
					write_reg(ffa_pkg::REG_BASE, 16'd1000);
					write_reg(ffa_pkg::REG_END, 16'd1);
				end
				default: begin
					write_reg(ffa_pkg::REG_BASE, 16'($urandom_range(30000)));
					write_reg(ffa_pkg::REG_END, 16'($urandom_range(65535, 30001)));
				end
			endcase
			send_item(ffa_pkg::K_INIT, 16'($urandom), 6'($urandom));
			for (int n = 0; n < N_RANDOM / 6; n++) begin
				if (phase == 5 && n > N_RANDOM / 8) calm = 1;
				if (phase == 4 && n == 100) wait_drained();
				live = blk_cnt;
				case ($urandom_range(19))
					0: k = ffa_pkg::K_INIT;
					1, 2, 3: k = ffa_pkg::K_READ;
					4, 5, 6, 7, 8, 9, 10: k = ffa_pkg::K_FREE;
					default: k = ffa_pkg::K_ALLOC;
				endcase
				if (k == ffa_pkg::K_ALLOC) begin
					if ($urandom_range(15) == 0) send_item(k, 16'($urandom), 6'($urandom));
					else if ($urandom_range(30) == 0) send_item(k, 16'h0, 6'($urandom));
					else send_item(k, 16'($urandom_range(phase == 0 ? 4000 : 40, 1)),
						6'($urandom));
				end else if ($urandom_range(9) == 0 || live == 0)
					send_item(k, 16'($urandom), 6'($urandom));
				else
					send_item(k, 16'($urandom), 6'($urandom_range(live, 1)));
			end
			wait_drained();
		end
		write_reg(ffa_pkg::REG_BASE, ffa_pkg::RST_BASE);
		write_reg(ffa_pkg::REG_END, ffa_pkg::RST_END);
		send_item(ffa_pkg::K_INIT, 16'h0, 6'h0);
		wait_drained();

		$display("ran %0d items (alloc %0d, free %0d, read %0d, init %0d), %0d results seen",
			n_items, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], n_results);
		$display("register settings covered empty, minimal, full-width and random ranges");
		if (n_errors == 0 && pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* sim.f */
hdl/ffa_pkg.sv
hdl/ffa_ram.sv
hdl/ffa_dpath.sv
hdl/ffa_ctrl.sv
hdl/first_fit_block_allocator.sv
verif/first_fit_block_allocator_tb.sv
